/* hw/rtl/lpr_pkg.sv */
package lpr_pkg;

   // Operation codes of a request transaction
   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic {
      REG_CANVAS_WIDTH  = 1'b0,
      REG_CANVAS_HEIGHT = 1'b1
   } reg_index_type;

   localparam int DIM_BITS         = 9;
   localparam int BYTE_INDEX_BITS  = 13;
   localparam int MASK_BITS        = 8;
   localparam int PAGE_SHIFT       = 3;
   localparam int ROW_SEL_BITS     = 3;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 9'd128;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 9'd64;

   // Per-pixel status carried from the stepper to the address stage
   typedef struct packed {
      logic active;
      logic visible;
      logic value;
      logic last;
   } pix_flags_type;

endpackage

/* hw/rtl/lpr_setup.sv */
module lpr_setup import lpr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_op,
   input  logic signed [COORD_BITS-1:0] in_x_start,
   input  logic signed [COORD_BITS-1:0] in_y_start,
   input  logic signed [COORD_BITS-1:0] in_x_end,
   input  logic signed [COORD_BITS-1:0] in_y_end,
   input  logic                         in_value,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_op,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic signed [COORD_BITS-1:0] out_tx,
   output logic signed [COORD_BITS-1:0] out_ty,
   output logic signed [COORD_BITS:0]   out_span_x,
   output logic signed [COORD_BITS:0]   out_neg_span_y,
   output logic signed [COORD_BITS+1:0] out_err,
   output logic                         out_dir_x,
   output logic                         out_dir_y,
   output logic                         out_value
);

   logic                         valid_ff, valid_in;
   logic                         op_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, tx_ff, ty_ff;
   logic signed [COORD_BITS:0]   span_x_ff, span_x_in;
   logic signed [COORD_BITS:0]   nsy_ff, nsy_in;
   logic signed [COORD_BITS+1:0] err_ff, err_in;
   logic                         dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic                         value_ff;
   logic signed [COORD_BITS:0]   dx, dy;
   logic                         take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Span and initial error of a new line
   always_comb begin
      dx        = (COORD_BITS+1)'(in_x_end) - (COORD_BITS+1)'(in_x_start);
      dy        = (COORD_BITS+1)'(in_y_end) - (COORD_BITS+1)'(in_y_start);
      span_x_in = dx[COORD_BITS] ? -dx : dx;
      nsy_in    = dy[COORD_BITS] ? dy : -dy;
      dir_x_in  = dx[COORD_BITS] || (dx == '0);
      dir_y_in  = dy[COORD_BITS] || (dy == '0);
      err_in    = (COORD_BITS+2)'(span_x_in) + (COORD_BITS+2)'(nsy_in);
   end

   // Hold the stage until the stepper takes it
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff     <= in_op;
         x_ff      <= in_x_start;
         y_ff      <= in_y_start;
         tx_ff     <= in_x_end;
         ty_ff     <= in_y_end;
         span_x_ff <= span_x_in;
         nsy_ff    <= nsy_in;
         err_ff    <= err_in;
         dir_x_ff  <= dir_x_in;
         dir_y_ff  <= dir_y_in;
         value_ff  <= in_value;
      end
   end

   assign out_valid      = valid_ff;
   assign out_op         = op_ff;
   assign out_x          = x_ff;
   assign out_y          = y_ff;
   assign out_tx         = tx_ff;
   assign out_ty         = ty_ff;
   assign out_span_x     = span_x_ff;
   assign out_neg_span_y = nsy_ff;
   assign out_err        = err_ff;
   assign out_dir_x      = dir_x_ff;
   assign out_dir_y      = dir_y_ff;
   assign out_value      = value_ff;

endmodule

/* hw/rtl/lpr_stepper.sv */
module lpr_stepper import lpr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [DIM_BITS-1:0]          canvas_width,
   input  logic [DIM_BITS-1:0]          canvas_height,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_op,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic signed [COORD_BITS-1:0] in_tx,
   input  logic signed [COORD_BITS-1:0] in_ty,
   input  logic signed [COORD_BITS:0]   in_span_x,
   input  logic signed [COORD_BITS:0]   in_neg_span_y,
   input  logic signed [COORD_BITS+1:0] in_err,
   input  logic                         in_dir_x,
   input  logic                         in_dir_y,
   input  logic                         in_value,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output pix_flags_type                out_flags
);

   localparam int UW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   // Line state
   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic signed [COORD_BITS:0]   span_x_ff, span_x_in, nsy_ff, nsy_in;
   logic signed [COORD_BITS+1:0] err_ff, err_in;
   logic                         dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic                         value_ff, value_in;

   // Pixel register
   logic                         valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   pix_flags_type                flags_ff, flags_in;

   logic                         take, start, busy, last, on_canvas;
   logic                         move_x, move_y;
   logic signed [COORD_BITS+2:0] twice;
   logic [UW-1:0]                x_u, y_u;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign start    = (in_op == OP_START);
   assign busy     = start || active_ff;

   // Pick freshly set up line or the running one
   always_comb begin
      tgt_x_in  = start ? in_tx         : tgt_x_ff;
      tgt_y_in  = start ? in_ty         : tgt_y_ff;
      span_x_in = start ? in_span_x     : span_x_ff;
      nsy_in    = start ? in_neg_span_y : nsy_ff;
      dir_x_in  = start ? in_dir_x      : dir_x_ff;
      dir_y_in  = start ? in_dir_y      : dir_y_ff;
      value_in  = start ? in_value      : value_ff;
      pix_x_in  = start ? in_x          : cur_x_ff;
      pix_y_in  = start ? in_y          : cur_y_ff;
   end

   // Clip and endpoint check of the current pixel
   always_comb begin
      x_u       = UW'(unsigned'(pix_x_in));
      y_u       = UW'(unsigned'(pix_y_in));
      last      = (pix_x_in == tgt_x_in) && (pix_y_in == tgt_y_in);
      on_canvas = !pix_x_in[COORD_BITS-1] && !pix_y_in[COORD_BITS-1] &&
                  (x_u < UW'(canvas_width)) && (y_u < UW'(canvas_height));
   end

   // Advance one Bresenham step
   always_comb begin
      twice    = {(start ? in_err : err_ff), 1'b0};
      twice    = $signed({twice[COORD_BITS+2], twice[COORD_BITS+1:0]});
      move_x   = twice >= (COORD_BITS+3)'(nsy_in);
      move_y   = twice <= (COORD_BITS+3)'(span_x_in);
      err_in   = start ? in_err : err_ff;
      cur_x_in = pix_x_in;
      cur_y_in = pix_y_in;
      if (move_x) begin
         err_in   = err_in + (COORD_BITS+2)'(nsy_in);
         cur_x_in = dir_x_in ? pix_x_in - COORD_BITS'(1) : pix_x_in + COORD_BITS'(1);
      end
      if (move_y) begin
         err_in   = err_in + (COORD_BITS+2)'(span_x_in);
         cur_y_in = dir_y_in ? pix_y_in - COORD_BITS'(1) : pix_y_in + COORD_BITS'(1);
      end
      if (last) begin
         err_in   = start ? in_err : err_ff;
         cur_x_in = pix_x_in;
         cur_y_in = pix_y_in;
      end
      active_in = !last;
   end

   // Result of this transaction; zeros while idle
   always_comb begin
      flags_in.active  = busy;
      flags_in.visible = busy && on_canvas;
      flags_in.value   = busy && value_in;
      flags_in.last    = busy && last;
      valid_in         = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take && busy) begin
            active_ff <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pix_x_ff <= busy ? pix_x_in : '0;
         pix_y_ff <= busy ? pix_y_in : '0;
         flags_ff <= flags_in;
      end
      if (take && busy) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         span_x_ff <= span_x_in;
         nsy_ff    <= nsy_in;
         err_ff    <= err_in;
         dir_x_ff  <= dir_x_in;
         dir_y_ff  <= dir_y_in;
         value_ff  <= value_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = pix_x_ff;
   assign out_y     = pix_y_ff;
   assign out_flags = flags_ff;

endmodule

/* hw/rtl/lpr_address.sv */
module lpr_address import lpr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [DIM_BITS-1:0]          canvas_width,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  pix_flags_type                in_flags,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic [BYTE_INDEX_BITS-1:0]   out_index,
   output logic [MASK_BITS-1:0]         out_mask,
   output pix_flags_type                out_flags
);

   localparam int UW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   logic                         valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic [BYTE_INDEX_BITS-1:0]   index_ff, index_in;
   logic [MASK_BITS-1:0]         mask_ff, mask_in;
   pix_flags_type                flags_ff;
   logic                         take;
   logic [UW-1:0]                x_u, y_u;
   logic [DIM_BITS-1:0]          page, col;
   logic [2*DIM_BITS-1:0]        product, sum;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Page-organized byte address and row mask; zero when clipped
   always_comb begin
      x_u     = UW'(unsigned'(in_x));
      y_u     = UW'(unsigned'(in_y));
      page    = DIM_BITS'(y_u >> PAGE_SHIFT);
      col     = DIM_BITS'(x_u);
      product = (2*DIM_BITS)'(page) * (2*DIM_BITS)'(canvas_width);
      sum     = product + (2*DIM_BITS)'(col);
      if (in_flags.visible) begin
         index_in = BYTE_INDEX_BITS'(sum);
         mask_in  = MASK_BITS'(1) << y_u[ROW_SEL_BITS-1:0];
      end else begin
         index_in = '0;
         mask_in  = '0;
      end
   end

   // Hold the result until the consumer takes it
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_ff     <= in_x;
         y_ff     <= in_y;
         index_ff <= index_in;
         mask_ff  <= mask_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_index = index_ff;
   assign out_mask  = mask_ff;
   assign out_flags = flags_ff;

endmodule

/* hw/rtl/line_pixel_rasterizer_top.sv */
// Bresenham line generator for a page-organized monochrome framebuffer (eight rows
// per byte). A start transaction loads both endpoints and the draw value and returns
// the first pixel; each step transaction returns the next pixel, with last set at
// the second endpoint, after which step transactions return an all-zero result with
// active low until the next start. A start always drops any running line. Each result
// gives the pixel, a clip flag against canvas_width/canvas_height (CSR 0 and 1), the
// byte index width*(y/8)+x and the one-hot row mask; both are zero for clipped pixels.
// One transaction is accepted per clock unless rsp_ready stalls the pipeline; its result
// passes through three register stages: a setup register, the stepper whose error
// update is combinational, and the address register with the page-times-width
// multiply. Write the CSRs only while idle.
module line_pixel_rasterizer_top import lpr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [DIM_BITS-1:0]          csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   input  logic                         req_pixel_on,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_active,
   output logic                         rsp_inside_res,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic [BYTE_INDEX_BITS-1:0]   rsp_byte_index,
   output logic [MASK_BITS-1:0]         rsp_bit_mask,
   output logic                         rsp_draw_value,
   output logic                         rsp_last
);

   logic [DIM_BITS-1:0]          width_ff, height_ff;

   logic                         s1_valid, s1_ready, s1_op, s1_dir_x, s1_dir_y, s1_value;
   logic signed [COORD_BITS-1:0] s1_x, s1_y, s1_tx, s1_ty;
   logic signed [COORD_BITS:0]   s1_span_x, s1_nsy;
   logic signed [COORD_BITS+1:0] s1_err;

   logic                         s2_valid, s2_ready;
   logic signed [COORD_BITS-1:0] s2_x, s2_y;
   pix_flags_type                s2_flags, s3_flags;

   // Canvas size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_CANVAS_WIDTH:  width_ff  <= csr_data;
            REG_CANVAS_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lpr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_op          (req_operation),
      .in_x_start     (req_x_start),
      .in_y_start     (req_y_start),
      .in_x_end       (req_x_end),
      .in_y_end       (req_y_end),
      .in_value       (req_pixel_on),
      .out_valid      (s1_valid),
      .out_ready      (s1_ready),
      .out_op         (s1_op),
      .out_x          (s1_x),
      .out_y          (s1_y),
      .out_tx         (s1_tx),
      .out_ty         (s1_ty),
      .out_span_x     (s1_span_x),
      .out_neg_span_y (s1_nsy),
      .out_err        (s1_err),
      .out_dir_x      (s1_dir_x),
      .out_dir_y      (s1_dir_y),
      .out_value      (s1_value)
   );

   lpr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
      .clock         (clock),
      .reset         (reset),
      .canvas_width  (width_ff),
      .canvas_height (height_ff),
      .in_valid      (s1_valid),
      .in_ready      (s1_ready),
      .in_op         (s1_op),
      .in_x          (s1_x),
      .in_y          (s1_y),
      .in_tx         (s1_tx),
      .in_ty         (s1_ty),
      .in_span_x     (s1_span_x),
      .in_neg_span_y (s1_nsy),
      .in_err        (s1_err),
      .in_dir_x      (s1_dir_x),
      .in_dir_y      (s1_dir_y),
      .in_value      (s1_value),
      .out_valid     (s2_valid),
      .out_ready     (s2_ready),
      .out_x         (s2_x),
      .out_y         (s2_y),
      .out_flags     (s2_flags)
   );

   lpr_address #(.COORD_BITS(COORD_BITS)) u_address (
      .clock        (clock),
      .reset        (reset),
      .canvas_width (width_ff),
      .in_valid     (s2_valid),
      .in_ready     (s2_ready),
      .in_x         (s2_x),
      .in_y         (s2_y),
      .in_flags     (s2_flags),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_x        (rsp_pixel_x),
      .out_y        (rsp_pixel_y),
      .out_index    (rsp_byte_index),
      .out_mask     (rsp_bit_mask),
      .out_flags    (s3_flags)
   );

   assign rsp_active     = s3_flags.active;
   assign rsp_inside_res = s3_flags.visible;
   assign rsp_draw_value = s3_flags.value;
   assign rsp_last       = s3_flags.last;

endmodule
